// File: rtl/ovl_pkg.sv
// Package for the ordered value list: sizes, operation and status codes,
// item structs. Used by every module under rtl.
`default_nettype none
package ovl_pkg;
    localparam int Depth = 16;
    localparam int CntW  = $clog2(Depth + 1);
    localparam int IdxW  = $clog2(Depth);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_COUNT      = 3'd4,
        OP_DELETE     = 3'd5,
        OP_DEDUP      = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic [4:0]         match_count;
        logic [4:0]         size;
    } rsp_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_in;    // take left neighbor's value (push front, slot 0 gets key)
        logic shift_out;   // take right neighbor's value when marked
        logic load_back;   // slot at back index loads key
    } cell_cmd_t;

    function automatic logic [4:0] sat5(input logic [CntW-1:0] n);
        logic [4:0] r;
        if (CntW > 5 && n > CntW'(31)) r = 5'd31;
        else r = 5'(n);
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/ovl_cell.sv
// One slot of the list chain: holds a value, shifts toward either neighbor.
// Depends on ovl_pkg.
`default_nettype none
module ovl_cell (
    input  wire logic               clk,
    input  wire ovl_pkg::cell_cmd_t cmd,
    input  wire logic               is_back,    // this slot is the tail slot
    input  wire logic               close_gap,  // this slot is at or past the gap
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] left_val,
    input  wire logic signed [31:0] right_val,
    output logic signed [31:0]      val
);
    import ovl_pkg::*;
    logic signed [31:0] val_reg, val_next;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.shift_in)
            val_next = left_val;
        else if (cmd.load_back && is_back)
            val_next = key;
        else if (cmd.shift_out && close_gap)
            val_next = right_val;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
endmodule
`default_nettype wire

// File: rtl/ordered_value_list.sv
// Top level of the ordered value list: a chain of slot cells plus a sequencer.
// Depends on ovl_pkg and ovl_cell.
//
//   port group | dir | struct | handshake
//   req        | in  | req_t  | req_valid / req_stall
//   rsp        | out | rsp_t  | rsp_valid / rsp_stall
//
// Push, pop and clear go from idle to the done state, which loads the result
// register. Count and dedup scan every occupied slot, then pass through done;
// delete stops at the first match or runs the full scan on a miss.
// One item is worked at a time; a new item is taken in idle once the result
// register is free or being taken, so no item is taken before the last is done.
// Reset empties the list; slot contents are not cleared.
`default_nettype none
module ordered_value_list (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ovl_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ovl_pkg::rsp_t       rsp
);
    import ovl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CntW-1:0] occ_reg, occ_next;
    logic [CntW-1:0] idx_reg, idx_next;    // scan position
    logic [CntW-1:0] keep_reg, keep_next;  // dedup kept length
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [2:0] op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic [IdxW-1:0] gap_reg, gap_next;
    logic found_reg, found_next;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    cell_cmd_t cmd;
    logic signed [31:0] vals [Depth];
    logic [IdxW-1:0] back_idx;
    logic accept, out_free;
    logic signed [31:0] cur;
    logic [Depth-1:0] hit_prefix;
    logic dup;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !(state_reg == S_IDLE && out_free);
    assign accept    = req_valid && !req_stall;
    assign cur       = vals[idx_reg[IdxW-1:0]];

    // compare the current slot with every kept slot in parallel
    always_comb
    begin
        for (int i = 0; i < Depth; i++)
            hit_prefix[i] = (CntW'(i) < keep_reg) && (vals[i] == cur);
    end
    assign dup = |hit_prefix;

    genvar g;
    generate
        for (g = 0; g < Depth; g++)
        begin : g_cell
            ovl_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .is_back   (back_idx == IdxW'(g)),
                .close_gap (IdxW'(g) >= gap_next),
                .key       (key_next),
                .left_val  (g == 0 ? key_next : vals[(g == 0) ? 0 : g-1]),
                .right_val (g == Depth-1 ? vals[Depth-1] : vals[(g == Depth-1) ? g : g+1]),
                .val       (vals[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        occ_next = occ_reg;
        idx_next = idx_reg;
        keep_next = keep_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        key_next = key_reg;
        gap_next = gap_reg;
        found_next = found_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd = '0;
        back_idx = occ_reg[IdxW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = req.mode;
                    key_next = req.value;
                    idx_next = '0;
                    keep_next = '0;
                    cnt_next = '0;
                    found_next = 1'b0;
                    gap_next = '0;
                    rsp_next = '0;
                    unique case (op_t'(req.mode))
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (occ_reg == CntW'(Depth))
                                rsp_next.status = ST_FULL;
                            else
                            begin
                                if (req.mode == OP_PUSH_FRONT)
                                    cmd.shift_in = 1'b1;
                                else
                                    cmd.load_back = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (occ_reg == '0)
                                rsp_next.status = ST_MISS;
                            else if (req.mode == OP_POP_FRONT)
                            begin
                                rsp_next.popped_value = vals[0];
                                cmd.shift_out = 1'b1;
                                occ_next = occ_reg - 1'b1;
                            end
                            else
                            begin
                                rsp_next.popped_value =
                                    vals[IdxW'(occ_reg - 1'b1)];
                                occ_next = occ_reg - 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            occ_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                            state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= occ_reg)
                begin
                    state_next = S_DONE;
                    unique case (op_t'(op_reg))
                        OP_COUNT:
                        begin
                            rsp_next.match_count = sat5(cnt_reg);
                            rsp_next.status = (cnt_reg != '0) ? ST_OK : ST_MISS;
                        end
                        OP_DELETE:
                            rsp_next.status = ST_MISS;
                        OP_DEDUP:
                            occ_next = keep_reg;
                        default: ;
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    unique case (op_t'(op_reg))
                        OP_COUNT:
                            if (cur == key_reg) cnt_next = cnt_reg + 1'b1;
                        OP_DELETE:
                            if (cur == key_reg)
                            begin
                                // close the gap in the next cycle
                                gap_next = idx_reg[IdxW-1:0];
                                found_next = 1'b1;
                                state_next = S_DONE;
                            end
                        OP_DEDUP:
                            if (!dup)
                            begin
                                key_next = cur;
                                back_idx = keep_reg[IdxW-1:0];
                                cmd.load_back = 1'b1;
                                keep_next = keep_reg + 1'b1;
                            end
                        default: ;
                    endcase
                end
            end
            S_DONE:
            begin
                if (found_reg)
                begin
                    cmd.shift_out = 1'b1;
                    occ_next = occ_reg - 1'b1;
                    found_next = 1'b0;
                end
                rsp_next.size = sat5(occ_next);
                rsp_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg <= '0;
            rsp_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        keep_reg <= keep_next;
        cnt_reg <= cnt_next;
        op_reg <= op_next;
        key_reg <= key_next;
        gap_reg <= gap_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
endmodule
`default_nettype wire
